// ===== hdl/pidsc_pkg.sv =====
`default_nettype none

package pidsc_pkg;

  // Field and register widths
  localparam int unsigned ErrW   = 16;
  localparam int unsigned GainW  = 18;
  localparam int unsigned SumW   = 32;
  localparam int unsigned LevelW = 16;
  localparam int unsigned AngleW = 7;
  localparam int unsigned CfgIdxW = 2;

  // Shared multiplier: signed gain side and signed operand side
  localparam int unsigned MulAW  = GainW + 1;
  localparam int unsigned MulBW  = SumW + 1;
  localparam int unsigned ProdW  = MulAW + MulBW;

  // Output word layout
  localparam int unsigned OutDataW = 32;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegKp = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKi = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKd = 2'd2;

  // Gain values after reset
  localparam logic [GainW-1:0] KpReset = 18'd6554;
  localparam logic [GainW-1:0] KiReset = 18'd0;
  localparam logic [GainW-1:0] KdReset = 18'd66;

  // Full scale degrees of the steering angle
  localparam logic [MulAW-1:0] AngleFull = 19'd45;

  // Operand pair fed to the shared multiplier
  typedef enum logic [1:0] {
    MUL_KP,
    MUL_KI,
    MUL_KD,
    MUL_ANGLE
  } mul_sel_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     clamp_en;
    logic     out_load;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/pidsc_datapath.sv =====
`default_nettype none

module pidsc_datapath (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  pidsc_pkg::cmd_t                  cmd_i,
  input  wire  [pidsc_pkg::ErrW-1:0]       error_sample_i,
  input  wire                              cfg_we_i,
  input  wire  [pidsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [pidsc_pkg::GainW-1:0]      cfg_wdata_i,
  output logic [pidsc_pkg::LevelW-1:0]     drive_level_o,
  output logic [pidsc_pkg::AngleW-1:0]     steer_angle_o,
  output logic                             send_command_o,
  output logic                             clamped_o
);

  import pidsc_pkg::*;

  localparam logic signed [ProdW-1:0] OneQ28  = ProdW'(64'sd268435456);
  localparam logic signed [ProdW-1:0] MoneQ28 = -ProdW'(64'sd268435456);
  localparam logic signed [ProdW-1:0] BiasQ14 = ProdW'(64'sd16383);
  localparam logic signed [LevelW-1:0] PosOne = LevelW'(16384);
  localparam logic signed [LevelW-1:0] NegOne = -LevelW'(16384);

  logic [GainW-1:0] kp_q, ki_q, kd_q;

  logic signed [ErrW-1:0]   e_q;
  logic signed [ErrW-1:0]   prev_q, prev_d;
  logic signed [ErrW:0]     diff_q, diff_d;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic signed [SumW:0]     sum_wide;
  logic signed [ErrW-1:0]   e_in;

  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ProdW-1:0]  acc_q;

  logic signed [LevelW-1:0] level_q, level_d;
  logic                     clamp_q, clamp_d;
  logic signed [ProdW-1:0]  acc_biased;

  logic signed [21:0]       ang_prod;
  logic signed [21:0]       ang_biased;
  logic signed [AngleW-1:0] angle;

  // Gain registers, written from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= KpReset;
      ki_q <= KiReset;
      kd_q <= KdReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKp:   kp_q <= cfg_wdata_i;
        RegKi:   ki_q <= cfg_wdata_i;
        RegKd:   kd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Update the integral (saturating) and the derivative term on capture
  assign e_in     = $signed(error_sample_i);
  assign sum_wide = {sum_q[SumW-1], sum_q} + {{(SumW+1-ErrW){e_in[ErrW-1]}}, e_in};

  always_comb begin
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_d = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_d = sum_wide[SumW-1:0];
    end
    diff_d = {e_in[ErrW-1], e_in} - {prev_q[ErrW-1], prev_q};
    prev_d = e_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (cmd_i.capture) begin
      sum_q  <= sum_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      e_q    <= e_in;
      diff_q <= diff_d;
    end
  end

  // Select the operand pair of the shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_KP: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = MulBW'(e_q);
      end
      MUL_KI: begin
        mul_a = $signed({1'b0, ki_q});
        mul_b = MulBW'(sum_q);
      end
      MUL_KD: begin
        mul_a = $signed({1'b0, kd_q});
        mul_b = MulBW'(diff_q);
      end
      MUL_ANGLE: begin
        mul_a = $signed(AngleFull);
        mul_b = MulBW'(level_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Product register and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // Clamp to plus or minus one, otherwise truncate Q28 down to Q14
  assign acc_biased = acc_q + (acc_q[ProdW-1] ? BiasQ14 : '0);

  always_comb begin
    if (acc_q > OneQ28) begin
      level_d = PosOne;
      clamp_d = 1'b1;
    end else if (acc_q < MoneQ28) begin
      level_d = NegOne;
      clamp_d = 1'b1;
    end else begin
      level_d = acc_biased[14 +: LevelW];
      clamp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp_en) begin
      level_q <= level_d;
      clamp_q <= clamp_d;
    end
  end

  // Divide level*45 by 2^14, rounding toward zero
  assign ang_prod   = prod_q[21:0];
  assign ang_biased = ang_prod + (ang_prod[21] ? 22'sd16383 : 22'sd0);
  assign angle      = ang_biased[14 +: AngleW];

  // Output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      drive_level_o  <= level_q;
      steer_angle_o  <= angle;
      send_command_o <= (angle != '0);
      clamped_o      <= clamp_q;
    end
  end

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.out_load) |->
      ($signed(drive_level_o) <= PosOne) && ($signed(drive_level_o) >= NegOne))
    else $error("drive level outside plus or minus one");

  a_clamp_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.out_load) && clamped_o |->
      ($signed(drive_level_o) == PosOne) || ($signed(drive_level_o) == NegOne))
    else $error("clamped word without full scale level");

  a_sum_no_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture && !sum_q[SumW-1] && !error_sample_i[ErrW-1] |=>
      !sum_q[SumW-1])
    else $error("integral wrapped instead of saturating");

endmodule

`default_nettype wire

// ===== hdl/pidsc_ctrl.sv =====
`default_nettype none

module pidsc_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  wire              m_axis_tready,
  output pidsc_pkg::cmd_t  cmd_o
);

  import pidsc_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMulP  = 3'd1;
  localparam logic [2:0] StMulI  = 3'd2;
  localparam logic [2:0] StMulD  = 3'd3;
  localparam logic [2:0] StAcc   = 3'd4;
  localparam logic [2:0] StClamp = 3'd5;
  localparam logic [2:0] StAngle = 3'd6;
  localparam logic [2:0] StScale = 3'd7;

  logic [2:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       slot_free;

  assign slot_free     = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;

  // Step through the multiply and accumulate sequence
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_KP;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d = StMulP;
        end
      end
      StMulP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KP;
        cmd_o.acc_clr = 1'b1;
        state_d = StMulI;
      end
      StMulI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KI;
        cmd_o.acc_add = 1'b1;
        state_d = StMulD;
      end
      StMulD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KD;
        cmd_o.acc_add = 1'b1;
        state_d = StAcc;
      end
      StAcc: begin
        cmd_o.acc_add = 1'b1;
        state_d = StClamp;
      end
      StClamp: begin
        cmd_o.clamp_en = 1'b1;
        state_d = StAngle;
      end
      StAngle: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ANGLE;
        state_d = StScale;
      end
      StScale: begin
        // Hold here while the previous word still waits at the output
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output word valid: set on load, drop once taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while one is in flight");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> !$past(cmd_o.out_load))
    else $error("waiting output word overwritten");

endmodule

`default_nettype wire

// ===== hdl/pid_steering_controller.sv =====
// PID steering controller with output clamp.
//
// Input stream: one signed Q4.12 lane error per word on s_axis_tdata[15:0].
// Output stream: one word per input word on m_axis_tdata:
//   [15:0] drive level (Q1.14, clamped to plus or minus one), [22:16] steering
//   angle in degrees, [23] send command, [24] clamped, [31:25] zero.
// Gains kp, ki, kd (unsigned Q2.16) are written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i with indexes 0, 1, 2; index 3 is ignored. Write only when idle.
// Each accepted word passes states MulP, MulI, MulD, Acc, Clamp, Angle and Scale
// to the output register; one multiplier is shared over the three gain products
// and the angle scaling, and an accumulator sums the products in sequence.
// s_axis_tready is high only in idle, so no word is taken while one is in flight.
// The output register lets the next word be accepted while a finished word
// waits; if the receiver stalls, the second finished word holds inside the
// block until the output register frees up, and the input stays closed.
// Reset clears the integral and the previous error, loads the default gains
// (kp about 0.1, ki zero, kd about 0.001) and empties the output register.
`default_nettype none

module pid_steering_controller (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] error_sample
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] drive_level, [22:16] steer_angle,
                                      // [23] send_command, [24] clamped
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [17:0] cfg_wdata_i
);

  import pidsc_pkg::*;

  cmd_t              cmd;
  logic [LevelW-1:0] drive_level;
  logic [AngleW-1:0] steer_angle;
  logic              send_command;
  logic              clamped;

  pidsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  pidsc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .error_sample_i (s_axis_tdata[ErrW-1:0]),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .drive_level_o  (drive_level),
    .steer_angle_o  (steer_angle),
    .send_command_o (send_command),
    .clamped_o      (clamped)
  );

  // Pack the result word, highest field first
  assign m_axis_tdata = {
    {(OutDataW - LevelW - AngleW - 2){1'b0}},
    clamped,
    send_command,
    steer_angle,
    drive_level
  };

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pidsc_pkg::*;

  // Register index outside the gain set; writes to it must change nothing
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  // Longest legal quiet stretch is the receiver hold-off (HoldCycles) or a run of
  // random stalls at 81 in a hundred; StallLimit sits many times above either.
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 20;

  localparam longint SumMax    = 64'sd2147483647;
  localparam longint SumMin    = -64'sd2147483648;
  localparam longint OneQ28    = 64'sd268435456;
  localparam longint OneQ14    = 64'sd16384;
  localparam longint AngleSpan = 64'sd45;

  localparam logic [ErrW-1:0] ErrMax = 16'h7fff;
  localparam logic [ErrW-1:0] ErrMin = 16'h8000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // Output word, highest bits first
  typedef struct packed {
    logic [6:0]               pad;
    logic                     clamped;
    logic                     send_command;
    logic signed [AngleW-1:0] steer_angle;
    logic signed [LevelW-1:0] drive_level;
  } steer_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  logic [ErrW-1:0]     s_axis_tdata  = '0;
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  wire  [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [GainW-1:0]    cfg_wdata_i   = '0;

  // Controller copy: gains, integral and last error
  logic [GainW-1:0]       gain_p;
  logic [GainW-1:0]       gain_i;
  logic [GainW-1:0]       gain_d;
  logic signed [SumW-1:0] integ_q;
  logic signed [ErrW-1:0] last_err_q;

  logic [ErrW-1:0] error_feed[$];
  steer_word_t     expected_steer[$];

  idle_mode_e  idle_mode  = IDLE_NONE;
  logic        send_gap;
  logic        rcv_stall;
  logic        hold_req   = 1'b0;
  logic        hold_ack;
  int unsigned hold_left;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count   = 0;
  steer_word_t seen_w;
  steer_word_t want_w;

  pid_steering_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial forever #5 clk_i = ~clk_i;

  // Advance the controller by one error sample and form the word it returns
  function automatic steer_word_t pid_step(input logic signed [ErrW-1:0] err);
    longint      e_l;
    longint      diff;
    longint      acc;
    longint      u;
    longint      lvl;
    longint      ang;
    steer_word_t res;
    e_l  = err;
    diff = e_l - longint'(last_err_q);
    acc  = longint'(integ_q) + e_l;
    if (acc > SumMax) acc = SumMax;
    else if (acc < SumMin) acc = SumMin;
    integ_q    = acc[SumW-1:0];
    last_err_q = err;
    u = longint'(gain_p) * e_l + longint'(gain_i) * acc + longint'(gain_d) * diff;
    res = '0;
    if (u > OneQ28) begin
      lvl = OneQ14;
      res.clamped = 1'b1;
    end else if (u < -OneQ28) begin
      lvl = -OneQ14;
      res.clamped = 1'b1;
    end else begin
      lvl = u / OneQ14;
    end
    ang = lvl * AngleSpan / OneQ14;
    res.drive_level  = lvl[LevelW-1:0];
    res.steer_angle  = ang[AngleW-1:0];
    res.send_command = (ang != 0);
    return res;
  endfunction

  function automatic logic [ErrW-1:0] pick_error();
    case ($urandom_range(3))
      0: return ErrW'($urandom);
      3: begin
        case ($urandom_range(2))
          0:       return ErrMax;
          1:       return ErrMin;
          default: return '0;
        endcase
      end
      default: return ErrW'($urandom_range(8191)) - 16'd4096;
    endcase
  endfunction

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return GainW'($urandom_range(8192));
      default: return GainW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegKp:   gain_p = val;
      RegKi:   gain_i = val;
      RegKd:   gain_d = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_gains(input logic [GainW-1:0] kp, input logic [GainW-1:0] ki,
                           input logic [GainW-1:0] kd);
    write_reg(RegKp, kp);
    write_reg(RegKi, ki);
    write_reg(RegKd, kd);
  endtask

  // Hold until every word is sent and every result has come back; end on a falling edge
  task automatic wait_idle();
    do @(negedge clk_i);
    while (error_feed.size() != 0 || s_axis_tvalid || expected_steer.size() != 0);
  endtask

  // Offer error words from the feed; predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_steer.push_back(pid_step(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        case (idle_mode)
          IDLE_SEND: send_gap = $urandom_range(99) < 81;
          IDLE_BOTH: send_gap = $urandom_range(99) < 11;
          default:   send_gap = 1'b0;
        endcase
        if (error_feed.size() != 0 && !send_gap) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= error_feed.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Count down a long receiver hold-off each time one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ack  <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each result word against the oldest prediction; drive ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_w = m_axis_tdata;
        if (expected_steer.size() == 0) begin
          report_mismatch("word with nothing expected", m_axis_tdata, 0);
        end else begin
          want_w = expected_steer.pop_front();
          if (seen_w.drive_level !== want_w.drive_level)
            report_mismatch("drive_level", seen_w.drive_level, want_w.drive_level);
          if (seen_w.steer_angle !== want_w.steer_angle)
            report_mismatch("steer_angle", seen_w.steer_angle, want_w.steer_angle);
          if (seen_w.send_command !== want_w.send_command)
            report_mismatch("send_command", seen_w.send_command, want_w.send_command);
          if (seen_w.clamped !== want_w.clamped)
            report_mismatch("clamped", seen_w.clamped, want_w.clamped);
          if (seen_w.pad !== want_w.pad)
            report_mismatch("padding", seen_w.pad, want_w.pad);
        end
      end
      case (idle_mode)
        IDLE_RECV: rcv_stall = $urandom_range(99) < 81;
        IDLE_BOTH: rcv_stall = $urandom_range(99) < 11;
        default:   rcv_stall = 1'b0;
      endcase
      m_axis_tready <= !rcv_stall && (hold_left == 0);
    end
  end

  // Stop the run when work is outstanding but nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (error_feed.size() == 0 && !s_axis_tvalid && expected_steer.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    gain_p     = KpReset;
    gain_i     = KiReset;
    gain_d     = KdReset;
    integ_q    = '0;
    last_err_q = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset gains: zero, extremes, largest swings of the difference term
    @(negedge clk_i);
    error_feed = '{16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0001,
                   16'hffff, 16'h1000, 16'hf000, 16'h5555, 16'haaaa};
    wait_idle();

    // Unity kp: exactly plus and minus one, just beyond, zero angle, small angles
    set_gains(18'd65536, '0, '0);
    write_reg(RegSpare, '1);
    @(negedge clk_i);
    error_feed = '{16'h1000, 16'hf000, 16'h1001, 16'hefff, 16'h0001, 16'h016c,
                   16'hfe94, 16'h0000};
    wait_idle();

    // All gains at full scale: hard clamping both ways
    set_gains('1, '1, '1);
    @(negedge clk_i);
    error_feed = '{16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    wait_idle();

    // All gains zero
    set_gains('0, '0, '0);
    @(negedge clk_i);
    error_feed = '{16'h007b, 16'hfffb};

    // Random words over each idling pattern, fresh gains every half phase
    for (int ph = 0; ph < 4; ph++) begin
      for (int part = 0; part < 2; part++) begin
        wait_idle();
        idle_mode = idle_mode_e'(ph);
        set_gains(pick_gain(), pick_gain(), pick_gain());
        if (ph == 0 && part == 0) begin
          // Stall the receiver long enough for the block to back up its input
          @(posedge clk_i);
          hold_req <= ~hold_req;
        end
        @(negedge clk_i);
        repeat (95) error_feed.push_back(pick_error());
      end
    end
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pidsc_pkg.sv
hdl/pidsc_datapath.sv
hdl/pidsc_ctrl.sv
hdl/pid_steering_controller.sv
bench/tb_top.sv
